@@ hdl/uialu_pkg.sv @@
// Shared types and constants for the unsigned integer ALU.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package uialu_pkg;

    localparam int Width = 32;
    localparam int Stages = Width;

    typedef enum logic [3:0] {
        CMD_AND = 4'd0,
        CMD_OR  = 4'd1,
        CMD_XOR = 4'd2,
        CMD_SHL = 4'd3,
        CMD_SHR = 4'd4,
        CMD_ADD = 4'd5,
        CMD_SUB = 4'd6,
        CMD_MUL = 4'd7,
        CMD_DIV = 4'd8,
        CMD_MOD = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    // Item state carried from cell to cell.
    typedef struct packed {
        logic                 valid;
        logic [3:0]           cmd;
        logic [Width-1:0]     a;
        logic [Width-1:0]     b;
        logic [Width-1:0]     rem;      // partial remainder of the divider
        logic [Width-1:0]     quo;      // quotient bits, shifted in from the right
        logic [Width-1:0]     acc;      // multiplier accumulator, low bits
        logic                 mul_ovf;  // product has spilled above Width bits
    } cell_t;

endpackage

@@ hdl/uialu_cell.sv @@
// One cell of the ALU chain: one restoring divide step and one
// shift-add multiply step. Depends on uialu_pkg.
`timescale 1ns / 1ps

module uialu_cell
    import uialu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  [$clog2(Width)-1:0] bit_idx,
    input  cell_t din,
    output cell_t dout
);

    cell_t dout_reg;
    cell_t dout_next;

    logic [Width:0]     trial;
    logic [Width:0]     sum;
    logic [Width-1:0]   addend;
    logic [2*Width-1:0] wide;

    // One step of each iterative unit.
    always_comb
    begin
        dout_next = din;
        // Divide: bring in bit bit_idx of a, subtract b if it fits.
        trial = {din.rem, din.a[bit_idx]};
        if (trial >= {1'b0, din.b})
        begin
            trial = trial - {1'b0, din.b};
            dout_next.quo = {din.quo[Width-2:0], 1'b1};
        end
        else
        begin
            dout_next.quo = {din.quo[Width-2:0], 1'b0};
        end
        dout_next.rem = trial[Width-1:0];
        // Multiply: add a shifted by bit_idx when that bit of b is set.
        wide = {{Width{1'b0}}, din.a} << bit_idx;
        addend = din.b[bit_idx] ? wide[Width-1:0] : '0;
        sum = {1'b0, din.acc} + {1'b0, addend};
        dout_next.acc = sum[Width-1:0];
        dout_next.mul_ovf = din.mul_ovf | sum[Width]
            | (din.b[bit_idx] && (wide[2*Width-1:Width] != '0));
    end

    // Stage register; reset empties the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

@@ hdl/unsigned_integer_alu.sv @@
// Top level of the unsigned integer ALU: a chain of uialu_cell stages
// and the final result selection. Depends on uialu_pkg and uialu_cell.
`timescale 1ns / 1ps

// Usage:
// Drive cmd, operand_a and operand_b and raise start; the item is taken
// at a clock edge where start is high and busy is low. busy is always
// low, so a new item may be given in every cycle.
// Every item runs through a chain of Width cells (32), one cell per
// cycle; each cell does one divide step and one multiply step. The
// result is registered at the output after the last cell, with done high
// for exactly one cycle, in the order the items were given.
// Throughput is one item per clock cycle; each cell of the chain gives
// one bit of quotient and of product.
// The receiver cannot stall: a result is shown for one cycle only.
// Reset clears all valid flags, so items in flight are dropped and
// done stays low until a new item has passed through the chain.
// Opcodes 10 to 15 give a zero result with status ok.
module unsigned_integer_alu
    import uialu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        done,
    output logic [31:0] result,
    output logic [1:0]  status,
    output logic        a_greater,
    output logic        a_less,
    output logic        a_equal
);

    cell_t chain [0:Stages];

    logic              done_reg;
    logic [31:0]       result_reg;
    logic [1:0]        status_reg;
    logic              a_greater_reg;
    logic              a_less_reg;
    logic              a_equal_reg;
    logic [31:0]       result_next;
    logic [1:0]        status_next;
    logic [Width:0]    add_sum;
    cell_t             head;
    cell_t             last;

    assign busy = 1'b0;

    // Load the head of the chain.
    always_comb
    begin
        head         = '0;
        head.valid   = start;
        head.cmd     = cmd;
        head.a       = operand_a[Width-1:0];
        head.b       = operand_b[Width-1:0];
    end

    assign chain[0] = head;

    // Cells, most significant dividend bit first.
    for (genvar i = 0; i < Stages; i++)
    begin : g_cell
        localparam logic [$clog2(Width)-1:0] Idx = $clog2(Width)'(Width - 1 - i);
        uialu_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bit_idx (Idx),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    assign last = chain[Stages];

    // Final selection on the item leaving the chain.
    always_comb
    begin
        result_next = '0;
        status_next = ST_OK;
        add_sum = {1'b0, last.a} + {1'b0, last.b};
        case (last.cmd)
            CMD_AND: result_next = last.a & last.b;
            CMD_OR:  result_next = last.a | last.b;
            CMD_XOR: result_next = last.a ^ last.b;
            CMD_SHL: result_next = (last.b >= 32'(Width)) ? '0 : last.a << last.b;
            CMD_SHR: result_next = (last.b >= 32'(Width)) ? '0 : last.a >> last.b;
            CMD_ADD:
            begin
                result_next = add_sum[Width-1:0];
                if (add_sum[Width])
                begin
                    status_next = ST_OVERFLOW;
                end
            end
            CMD_SUB:
            begin
                if (last.a < last.b)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    result_next = last.a - last.b;
                end
            end
            CMD_MUL:
            begin
                result_next = last.acc;
                if (last.mul_ovf)
                begin
                    status_next = ST_OVERFLOW;
                end
            end
            CMD_DIV, CMD_MOD:
            begin
                if (last.b == '0)
                begin
                    status_next = ST_DIVZERO;
                end
                else if (last.cmd == CMD_DIV)
                begin
                    result_next = last.quo;
                end
                else
                begin
                    result_next = last.rem;
                end
            end
            default: result_next = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        status_reg    <= status_next;
        a_greater_reg <= last.a > last.b;
        a_less_reg    <= last.a < last.b;
        a_equal_reg   <= last.a == last.b;
    end

    assign done      = done_reg;
    assign result    = result_reg;
    assign status    = status_reg;
    assign a_greater = a_greater_reg;
    assign a_less    = a_less_reg;
    assign a_equal   = a_equal_reg;

endmodule
